// File: hw/rtl/puf_pkg.sv
// ----------------------------------------------------------------------------
// puf_pkg
// Types and constants shared by the persistent union-find block.
// ----------------------------------------------------------------------------
package puf_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned NODES  = 1 << NODE_W;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 16;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_MERGE = 2'd0;
  localparam func_t FUNC_SAME  = 2'd1;
  localparam func_t FUNC_SIZE  = 2'd2;
  localparam func_t FUNC_RSVD  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LRD,
    ST_LCHK,
    ST_CRD,
    ST_CCHK,
    ST_HRD,
    ST_HCHK,
    ST_BS,
    ST_BRD,
    ST_BCHK,
    ST_MERGE
  } state_e;

endpackage

// File: hw/rtl/persistent_union_find.sv
// ----------------------------------------------------------------------------
// persistent_union_find
// Partially persistent union-find over 64 nodes with merge, same-set and
// size-at-time requests, run by a small sequencer over three memories.
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit up)
// s_axis    in   func[1:0] node_a[7:2] node_b[13:8] query_time[29:14]
// m_axis    out  flag[0] set_size[7:1] status[8]
// Each walk step waits on a registered link read; trees stay at most 6 links deep.
// Merge walks both roots, reads counts and sizes, then writes; same, or merge in one
// set, ends after the walks; size walks, then binary-searches the size history
// (k <= floor(log2 c)+1 probes); refused merge or unused kind answers from idle.
// Reset clears link valid bits and count valid bits at once; no clearing pass.
// A result beat waits in the output register; input is held off until it drains.
// ----------------------------------------------------------------------------
module persistent_union_find (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // func, node_a, node_b, query_time, zero pad
  input  logic [puf_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // flag, set_size, status, zero pad
  output logic [puf_pkg::M_DATA_W-1:0]  m_axis_tdata_o
);
  import puf_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SIZE_W-1:0] ONE_SZ   = SIZE_W'(1);

  logic [NODE_W+TIME_W-1:0] lk_mem [NODES];
  logic [SIZE_W+TIME_W-1:0] hs_mem [NODES*NODES];
  logic [SIZE_W-1:0]        ct_mem [NODES];

  logic [NODE_W+TIME_W-1:0] lk_rd_q;
  logic [SIZE_W+TIME_W-1:0] hs_rd_q;
  logic [SIZE_W-1:0]        ct_rd_q;

  logic [NODES-1:0] lv_q, lv_d, cv_q, cv_d;

  state_e state_q, state_d;
  func_t  func_q, func_d;
  logic [NODE_W-1:0] b_q, b_d, u_q, u_d, ra_q, ra_d, rb_q, rb_d, r_q, r_d;
  logic [NODE_W-1:0] hidx_q, hidx_d;
  logic [TIME_W-1:0] t_q, t_d, cur_q, cur_d;
  logic [SIZE_W-1:0] ca_q, ca_d, cb_q, cb_d, sa_q, sa_d, sb_q, sb_d;
  logic [SIZE_W-1:0] lo_q, lo_d, hi_q, hi_d, ans_q, ans_d;
  logic phase_q, phase_d;

  logic ov_q, ov_d, flag_q, flag_d, stat_q, stat_d;
  logic [SIZE_W-1:0] osz_q, osz_d;

  logic lk_we, hs_we, ct_we;
  logic [NODE_W-1:0] lk_waddr, ct_waddr;
  logic [2*NODE_W-1:0] hs_waddr;
  logic [NODE_W+TIME_W-1:0] lk_wdata;
  logic [SIZE_W+TIME_W-1:0] hs_wdata;
  logic [SIZE_W-1:0] ct_wdata;

  logic s_acc, out_free;
  logic [SIZE_W-1:0] cnt_c, hsz, mid, cw;
  logic [TIME_W-1:0] htime;
  logic swap;

  assign out_free        = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {{(M_DATA_W-SIZE_W-2){1'b0}}, stat_q, osz_q, flag_q};

  assign cnt_c = cv_q[r_q] ? ct_rd_q : ONE_SZ;
  assign hsz   = (hidx_q == '0) ? ONE_SZ : hs_rd_q[SIZE_W+TIME_W-1:TIME_W];
  assign htime = (hidx_q == '0) ? '0 : hs_rd_q[TIME_W-1:0];
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);
  assign swap  = sa_q < sb_q;
  assign cw    = swap ? cb_q : ca_q;

  always_ff @(posedge clk_i) begin
    lk_rd_q <= lk_mem[u_q];
    hs_rd_q <= hs_mem[{r_q, hidx_q}];
    ct_rd_q <= ct_mem[r_q];
    if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
    if (hs_we) hs_mem[hs_waddr] <= hs_wdata;
    if (ct_we) ct_mem[ct_waddr] <= ct_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lv_q    <= '0;
      cv_q    <= '0;
      cur_q   <= '0;
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lv_q    <= lv_d;
      cv_q    <= cv_d;
      cur_q   <= cur_d;
      ov_q    <= ov_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;  b_q  <= b_d;   u_q  <= u_d;   ra_q <= ra_d;
    rb_q   <= rb_d;    r_q  <= r_d;   hidx_q <= hidx_d; t_q <= t_d;
    ca_q   <= ca_d;    cb_q <= cb_d;  sa_q <= sa_d;  sb_q <= sb_d;
    lo_q   <= lo_d;    hi_q <= hi_d;  ans_q <= ans_d;
    flag_q <= flag_d;  stat_q <= stat_d; osz_q <= osz_d;
  end

  always_comb begin
    state_d = state_q; func_d = func_q; b_d = b_q; u_d = u_q; ra_d = ra_q;
    rb_d = rb_q; r_d = r_q; hidx_d = hidx_q; t_d = t_q; ca_d = ca_q; cb_d = cb_q;
    sa_d = sa_q; sb_d = sb_q; lo_d = lo_q; hi_d = hi_q; ans_d = ans_q;
    phase_d = phase_q; lv_d = lv_q; cv_d = cv_q; cur_d = cur_q;
    ov_d = ov_q && !m_axis_tready_i; flag_d = flag_q; stat_d = stat_q; osz_d = osz_q;
    lk_we = 1'b0; hs_we = 1'b0; ct_we = 1'b0;
    lk_waddr = '0; ct_waddr = '0; hs_waddr = '0;
    lk_wdata = '0; hs_wdata = '0; ct_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          func_d  = s_axis_tdata_i[1:0];
          u_d     = s_axis_tdata_i[7:2];
          b_d     = s_axis_tdata_i[13:8];
          t_d     = s_axis_tdata_i[29:14];
          phase_d = 1'b0;
          flag_d  = 1'b0;
          stat_d  = 1'b0;
          osz_d   = '0;
          priority if (s_axis_tdata_i[1:0] == FUNC_MERGE) begin
            if (cur_q == TIME_MAX) begin
              stat_d = 1'b1;
              ov_d   = 1'b1;
            end else begin
              cur_d   = cur_q + 1'b1;
              t_d     = cur_q + 1'b1;
              state_d = ST_LRD;
            end
          end else if (s_axis_tdata_i[1:0] == FUNC_SAME ||
                       s_axis_tdata_i[1:0] == FUNC_SIZE) begin
            state_d = ST_LRD;
          end else begin
            ov_d = 1'b1;
          end
        end
      end
      ST_LRD: state_d = ST_LCHK;
      ST_LCHK: begin
        if (lv_q[u_q] && lk_rd_q[TIME_W-1:0] <= t_q) begin
          u_d     = lk_rd_q[NODE_W+TIME_W-1:TIME_W];
          state_d = ST_LRD;
        end else if (!phase_q) begin
          ra_d = u_q;
          if (func_q == FUNC_SIZE) begin
            r_d     = u_q;
            state_d = ST_CRD;
          end else begin
            u_d     = b_q;
            phase_d = 1'b1;
            state_d = ST_LRD;
          end
        end else begin
          rb_d = u_q;
          if (func_q == FUNC_SAME || ra_q == u_q) begin
            if (out_free) begin
              flag_d  = (func_q == FUNC_SAME) && (ra_q == u_q);
              ov_d    = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            r_d     = ra_q;
            phase_d = 1'b0;
            state_d = ST_CRD;
          end
        end
      end
      ST_CRD: state_d = ST_CCHK;
      ST_CCHK: begin
        if (func_q == FUNC_SIZE) begin
          lo_d    = '0;
          hi_d    = cnt_c;
          ans_d   = '0;
          state_d = ST_BS;
        end else begin
          if (!phase_q) ca_d = cnt_c;
          else          cb_d = cnt_c;
          hidx_d  = NODE_W'(cnt_c - 1'b1);
          state_d = ST_HRD;
        end
      end
      ST_HRD: state_d = ST_HCHK;
      ST_HCHK: begin
        if (func_q == FUNC_SIZE) begin
          if (out_free) begin
            osz_d   = hsz;
            ov_d    = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (!phase_q) begin
          sa_d    = hsz;
          r_d     = rb_q;
          phase_d = 1'b1;
          state_d = ST_CRD;
        end else begin
          sb_d    = hsz;
          state_d = ST_MERGE;
        end
      end
      ST_BS: begin
        if (lo_q < hi_q) begin
          hidx_d  = NODE_W'(mid);
          state_d = ST_BRD;
        end else begin
          hidx_d  = NODE_W'(ans_q);
          state_d = ST_HRD;
        end
      end
      ST_BRD: state_d = ST_BCHK;
      ST_BCHK: begin
        if (htime <= t_q) begin
          ans_d = {1'b0, hidx_q};
          lo_d  = {1'b0, hidx_q} + 1'b1;
        end else begin
          hi_d  = {1'b0, hidx_q};
        end
        state_d = ST_BS;
      end
      ST_MERGE: begin
        if (out_free) begin
          if (cw < SIZE_W'(NODES)) begin
            hs_we    = 1'b1;
            hs_waddr = {swap ? rb_q : ra_q, cw[NODE_W-1:0]};
            hs_wdata = {sa_q + sb_q, cur_q};
            ct_we    = 1'b1;
            ct_waddr = swap ? rb_q : ra_q;
            ct_wdata = cw + 1'b1;
            cv_d[swap ? rb_q : ra_q] = 1'b1;
          end
          lk_we    = 1'b1;
          lk_waddr = swap ? ra_q : rb_q;
          lk_wdata = {swap ? rb_q : ra_q, cur_q};
          lv_d[swap ? ra_q : rb_q] = 1'b1;
          flag_d  = 1'b1;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q >= $past(cur_q))
    else $error("time counter went back");
  a_merge_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MERGE |-> ra_q != rb_q)
    else $error("merge of one root");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == ST_IDLE)
    else $error("ready while busy");
  a_link_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lv_q) >= $countones($past(lv_q)))
    else $error("link lost");

endmodule
